FILE: sv/bbrs_pkg.sv
// Shared types and codes for the block boundary request splitter.
// No dependencies; the core, front, queue, back and checker files refer to it by scoped names.
package bbrs_pkg;

    // Input action codes
    localparam logic ACT_SPLIT = 1'b0;
    localparam logic ACT_DONE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SIZE = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ST_BUSY = 2'd3;

    // Block offset bounds and reset value
    localparam logic [3:0] BOB_MIN   = 4'd4;
    localparam logic [3:0] BOB_MAX   = 4'd10;
    localparam logic [3:0] BOB_RESET = 4'd6;

    // Work descriptor passed from front to back through the queue
    typedef struct packed {
        logic               single;   // one precomputed result, no splitting
        logic [63:0]        addr;
        logic [9:0]         size;
        logic [5:0]         idx;
        logic [3:0]         proc;
        logic signed [63:0] tag;
        logic [1:0]         status;
        logic               all_done;
        logic [3:0]         bits;     // clamped block offset bits
        logic [6:0]         total;    // chunk count, up to 33
    } job_t;

    // One result transaction
    typedef struct packed {
        logic [63:0]        chunk_address;
        logic [10:0]        chunk_bytes;
        logic [5:0]         chunk_index;
        logic [3:0]         out_processor;
        logic signed [63:0] out_tag;
        logic               last_chunk;
        logic [1:0]         status;
        logic               all_done;
    } rsp_t;

endpackage

FILE: sv/bbrs_if.sv
// Channel interfaces: request input, result output, configuration write.
// Depends on nothing; used by the core, the front end and the back end.
interface bbrs_req_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [63:0]        req_address;
    logic [9:0]         req_size;
    logic [3:0]         req_processor;
    logic signed [63:0] req_tag;
    logic [5:0]         done_index;

    modport source(output valid, action, req_address, req_size, req_processor, req_tag,
                   done_index, input ready);
    modport sink(input valid, action, req_address, req_size, req_processor, req_tag,
                 done_index, output ready);
endinterface

interface bbrs_rsp_if;
    logic               valid;
    logic               ready;
    logic [63:0]        chunk_address;
    logic [10:0]        chunk_bytes;
    logic [5:0]         chunk_index;
    logic [3:0]         out_processor;
    logic signed [63:0] out_tag;
    logic               last_chunk;
    logic [1:0]         status;
    logic               all_done;

    modport source(output valid, chunk_address, chunk_bytes, chunk_index, out_processor,
                   out_tag, last_chunk, status, all_done, input ready);
    modport sink(input valid, chunk_address, chunk_bytes, chunk_index, out_processor,
                 out_tag, last_chunk, status, all_done, output ready);
endinterface

interface bbrs_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

FILE: sv/block_boundary_request_splitter_core.sv
// A result passes through the job queue, the back end's working registers and the output register.
// Throughput: the back end emits one result per cycle while the output is not stalled; it
// loads each job in a separate step and takes the next job only after the current job's last result.
// The front takes a request whenever the job queue has room; config writes always taken.
// Reset (rst_n, async low) clears owner state, the queue and the output stage, and sets
// the block offset to 6. No clearing pass.
module block_boundary_request_splitter_core #(
    parameter int MAX_REQUEST_BYTES = 512,
    parameter int QUEUE_DEPTH       = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    bbrs_req_if.sink    req,
    bbrs_cfg_if.sink    cfg,
    bbrs_rsp_if.source  rsp
);

    logic           push_valid;
    logic           push_ready;
    bbrs_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_ready;
    bbrs_pkg::job_t pop_job;

    // Classification and owner tracking
    bbrs_front #(
        .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Decoupling queue
    bbrs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Chunk generation and output stage
    bbrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .rsp       (rsp)
    );

endmodule

FILE: sv/bbrs_front.sv
// Front end: accepts requests, checks them against the owner state, updates
// that state and pushes one job per transaction. Uses bbrs_pkg and bbrs_if.
module bbrs_front #(
    parameter int MAX_REQUEST_BYTES = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    bbrs_req_if.sink      req,
    bbrs_cfg_if.sink      cfg,
    output logic          push_valid,
    input  logic          push_ready,
    output bbrs_pkg::job_t push_job
);

    logic [3:0]         bob_reg;
    logic               busy_reg,  busy_next;
    logic [5:0]         total_reg, total_next;
    logic [5:0]         compl_reg, compl_next;
    logic [3:0]         owner_proc_reg, owner_proc_next;
    logic signed [63:0] owner_tag_reg,  owner_tag_next;

    logic [3:0]  bits;
    logic [9:0]  blk_mask;
    logic [9:0]  size_m1;
    logic [64:0] end_sum;
    logic [10:0] span;
    logic [10:0] span_sh;
    logic [6:0]  total_calc;
    logic        accept;
    logic        size_bad;
    logic        done_ok;
    logic [5:0]  compl_inc;

    assign cfg.ready  = 1'b1;
    assign req.ready  = push_ready;
    assign push_valid = req.valid;
    assign accept     = req.valid && push_ready;

    // Block offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bob_reg <= bbrs_pkg::BOB_RESET;
        end
        else if (cfg.valid)
        begin
            bob_reg <= cfg.data;
        end
    end

    // Clamped block geometry and chunk count
    always_comb
    begin
        if (bob_reg < bbrs_pkg::BOB_MIN)
        begin
            bits = bbrs_pkg::BOB_MIN;
        end
        else if (bob_reg > bbrs_pkg::BOB_MAX)
        begin
            bits = bbrs_pkg::BOB_MAX;
        end
        else
        begin
            bits = bob_reg;
        end
        blk_mask   = 10'((11'd1 << bits) - 11'd1);
        size_m1    = req.req_size - 10'd1;
        end_sum    = {1'b0, req.req_address} + {55'd0, size_m1};
        span       = {1'b0, req.req_address[9:0] & blk_mask} + {1'b0, size_m1};
        span_sh    = span >> bits;
        total_calc = span_sh[6:0] + 7'd1;
        size_bad   = (req.req_size == 10'd0) ||
                     ({22'd0, req.req_size} > 32'(MAX_REQUEST_BYTES));
        done_ok    = busy_reg && (req.req_processor == owner_proc_reg) &&
                     (req.req_tag == owner_tag_reg) && (compl_reg < total_reg) &&
                     (req.done_index == compl_reg);
        compl_inc  = compl_reg + 6'd1;
    end

    // Classification, job build and owner state update
    always_comb
    begin
        busy_next       = busy_reg;
        total_next      = total_reg;
        compl_next      = compl_reg;
        owner_proc_next = owner_proc_reg;
        owner_tag_next  = owner_tag_reg;

        push_job          = '0;
        push_job.single   = 1'b1;
        push_job.addr     = req.req_address;
        push_job.size     = req.req_size;
        push_job.idx      = 6'd0;
        push_job.proc     = req.req_processor;
        push_job.tag      = req.req_tag;
        push_job.status   = bbrs_pkg::ST_OK;
        push_job.all_done = 1'b0;
        push_job.bits     = bits;
        push_job.total    = total_calc;

        if (req.action == bbrs_pkg::ACT_SPLIT)
        begin
            if (busy_reg)
            begin
                push_job.status = bbrs_pkg::ST_BUSY;
            end
            else if (size_bad)
            begin
                push_job.status = bbrs_pkg::ST_SIZE;
            end
            else if (end_sum[64])
            begin
                push_job.status = bbrs_pkg::ST_OVF;
            end
            else
            begin
                push_job.single = 1'b0;
                busy_next       = 1'b1;
                total_next      = total_calc[5:0];
                compl_next      = 6'd0;
                owner_proc_next = req.req_processor;
                owner_tag_next  = req.req_tag;
            end
        end
        else
        begin
            push_job.addr = 64'd0;
            push_job.idx  = req.done_index;
            if (done_ok)
            begin
                compl_next        = compl_inc;
                push_job.proc     = owner_proc_reg;
                push_job.tag      = owner_tag_reg;
                push_job.all_done = (compl_inc == total_reg);
                if (compl_inc == total_reg)
                begin
                    busy_next = 1'b0;
                end
            end
            else
            begin
                push_job.status = bbrs_pkg::ST_BUSY;
            end
        end
    end

    // Owner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            total_reg      <= 6'd0;
            compl_reg      <= 6'd0;
            owner_proc_reg <= 4'd0;
            owner_tag_reg  <= 64'sd0;
        end
        else if (accept)
        begin
            busy_reg       <= busy_next;
            total_reg      <= total_next;
            compl_reg      <= compl_next;
            owner_proc_reg <= owner_proc_next;
            owner_tag_reg  <= owner_tag_next;
        end
    end

endmodule

FILE: sv/bbrs_queue.sv
// Small flop-based FIFO of job descriptors between front and back.
// Uses bbrs_pkg::job_t.
module bbrs_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  bbrs_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output bbrs_pkg::job_t pop_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bbrs_pkg::job_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: sv/bbrs_back.sv
// Back end: takes jobs from the queue and, while the output stage is not stalled, emits one
// result per cycle into a registered output stage. Uses bbrs_pkg and bbrs_rsp_if.
module bbrs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  bbrs_pkg::job_t pop_job,
    bbrs_rsp_if.source     rsp
);

    logic               act_reg;
    logic               single_reg;
    logic [63:0]        addr_reg,  addr_next;
    logic [9:0]         rem_reg,   rem_next;
    logic [6:0]         idx_reg;
    logic [6:0]         total_reg;
    logic [3:0]         bits_reg;
    logic [3:0]         proc_reg;
    logic signed [63:0] tag_reg;
    logic [1:0]         status_reg;
    logic               all_done_reg;

    logic               out_valid_reg;
    bbrs_pkg::rsp_t     out_reg, out_next;

    logic        slot_free;
    logic        emit;
    logic        last;
    logic [10:0] blk;
    logic [9:0]  blk_mask;
    logic [10:0] avail;
    logic [10:0] bytes;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign emit      = act_reg && slot_free;
    assign pop_ready = !act_reg;

    // Chunk arithmetic for the current position
    always_comb
    begin
        blk       = 11'd1 << bits_reg;
        blk_mask  = 10'(blk - 11'd1);
        avail     = blk - {1'b0, addr_reg[9:0] & blk_mask};
        bytes     = ({1'b0, rem_reg} < avail) ? {1'b0, rem_reg} : avail;
        rem_next  = rem_reg - bytes[9:0];
        addr_next = (rem_next != 10'd0) ? addr_reg + {53'd0, bytes} : addr_reg;
        last      = single_reg || ((idx_reg + 7'd1) == total_reg);
    end

    // Result formatting
    always_comb
    begin
        out_next.chunk_address = addr_reg;
        out_next.chunk_bytes   = single_reg ? 11'd0 : bytes;
        out_next.chunk_index   = idx_reg[5:0];
        out_next.out_processor = proc_reg;
        out_next.out_tag       = tag_reg;
        out_next.last_chunk    = last;
        out_next.status        = status_reg;
        out_next.all_done      = all_done_reg;
    end

    // Job control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else if (!act_reg)
        begin
            act_reg <= pop_valid;
        end
        else if (emit && last)
        begin
            act_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (!act_reg)
        begin
            single_reg   <= pop_job.single;
            addr_reg     <= pop_job.addr;
            rem_reg      <= pop_job.size;
            idx_reg      <= {1'b0, pop_job.idx};
            total_reg    <= pop_job.total;
            bits_reg     <= pop_job.bits;
            proc_reg     <= pop_job.proc;
            tag_reg      <= pop_job.tag;
            status_reg   <= pop_job.status;
            all_done_reg <= pop_job.all_done;
        end
        else if (emit)
        begin
            addr_reg <= addr_next;
            rem_reg  <= rem_next;
            idx_reg  <= idx_reg + 7'd1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.chunk_address = out_reg.chunk_address;
    assign rsp.chunk_bytes   = out_reg.chunk_bytes;
    assign rsp.chunk_index   = out_reg.chunk_index;
    assign rsp.out_processor = out_reg.out_processor;
    assign rsp.out_tag       = out_reg.out_tag;
    assign rsp.last_chunk    = out_reg.last_chunk;
    assign rsp.status        = out_reg.status;
    assign rsp.all_done      = out_reg.all_done;

endmodule

FILE: sv/bbrs_checker.sv
// Port-level checks on the result channel of the splitter core.
// Depends on bbrs_pkg; bound to block_boundary_request_splitter_core below.
module bbrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [10:0] rsp_chunk_bytes,
    input logic        rsp_last_chunk,
    input logic [1:0]  rsp_status,
    input logic        rsp_all_done
);

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chunk_bytes) &&
        $stable(rsp_status))
        else $error("result changed while stalled");

    // Error results are single and empty
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != bbrs_pkg::ST_OK) |->
        rsp_last_chunk && (rsp_chunk_bytes == 11'd0) && !rsp_all_done)
        else $error("error result not a lone empty result");

    // Completion of the whole request is a final ok result
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_all_done |-> rsp_last_chunk && (rsp_status == bbrs_pkg::ST_OK))
        else $error("all_done on a non-final or failed result");

    // A chunk never exceeds the largest block
    a_chunk_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_chunk_bytes <= 11'd1024)
        else $error("chunk larger than a block");

endmodule

bind block_boundary_request_splitter_core bbrs_checker u_bbrs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_chunk_bytes (rsp.chunk_bytes),
    .rsp_last_chunk  (rsp.last_chunk),
    .rsp_status      (rsp.status),
    .rsp_all_done    (rsp.all_done)
);
